>>> hdl/crp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_pkg: shared types and constants of the cell reference parser
// Holds the phase codes, the parse state record, the result record and
// the grammar constants used by the step logic and the top level.
// ----------------------------------------------------------------------------
package crp_pkg;

	localparam logic [2:0] PH_START   = 3'd0;
	localparam logic [2:0] PH_DOLLAR  = 3'd1;
	localparam logic [2:0] PH_LETTERS = 3'd2;
	localparam logic [2:0] PH_ROWWS   = 3'd3;
	localparam logic [2:0] PH_SIGN    = 3'd4;
	localparam logic [2:0] PH_DIGITS  = 3'd5;
	localparam logic [2:0] PH_FAIL    = 3'd6;

	localparam logic [14:0] COL_MAX   = 15'd16384;
	localparam logic [20:0] ROW_MAX   = 21'd1048576;
	localparam logic [4:0]  COL_RADIX = 5'd26;
	localparam logic [3:0]  ROW_RADIX = 4'd10;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;

	typedef struct packed {
		logic [2:0]  phase;
		logic [14:0] col_acc;
		logic        col_ovf;
		logic [20:0] row_acc;
		logic        row_ovf;
		logic        row_neg;
		logic        digit_seen;
	} state_t;

	typedef struct packed {
		logic        ok;
		logic [20:0] row_number;
		logic [14:0] column_number;
	} result_t;

	localparam state_t STATE_RESET = '{PH_START, 15'd0, 1'b0, 21'd0, 1'b0, 1'b0, 1'b0};

endpackage

>>> hdl/crp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_step: next-state and result logic for one reference byte
// Applies one byte to the parse state and forms the result that the
// reference would give if this byte were its last.
// ----------------------------------------------------------------------------
module crp_step (
	input  crp_pkg::state_t  cur,
	input  logic [7:0]       char_byte,
	output crp_pkg::state_t  nxt,
	output crp_pkg::result_t res
);

	logic        is_upper;
	logic        is_lower;
	logic        is_letter;
	logic        is_digit;
	logic        is_space;
	logic [4:0]  letter_val;
	logic [3:0]  digit_val;
	logic [18:0] col_sum;
	logic [23:0] row_sum;
	logic        col_sat;
	logic        row_sat;
	logic [14:0] col_upd;
	logic [20:0] row_upd;
	logic        do_row_start;
	logic        good;

	assign is_upper  = (char_byte >= crp_pkg::CH_UPPER_A) && (char_byte <= crp_pkg::CH_UPPER_Z);
	assign is_lower  = (char_byte >= crp_pkg::CH_LOWER_A) && (char_byte <= crp_pkg::CH_LOWER_Z);
	assign is_letter = is_upper || is_lower;
	assign is_digit  = (char_byte >= crp_pkg::CH_ZERO) && (char_byte <= crp_pkg::CH_NINE);
	assign is_space  = (char_byte == crp_pkg::CH_SPACE) ||
		((char_byte >= crp_pkg::CH_TAB) && (char_byte <= crp_pkg::CH_CR));

	// Both cases map A..Z onto 1..26 from the low five bits.
	assign letter_val = char_byte[4:0];
	assign digit_val  = char_byte[3:0];

	assign col_sum = 19'(cur.col_acc) * 19'(crp_pkg::COL_RADIX) + 19'(letter_val);
	assign row_sum = 24'(cur.row_acc) * 24'(crp_pkg::ROW_RADIX) + 24'(digit_val);
	assign col_sat = cur.col_ovf || (col_sum > 19'(crp_pkg::COL_MAX));
	assign row_sat = cur.row_ovf || (row_sum > 24'(crp_pkg::ROW_MAX));
	assign col_upd = col_sat ? crp_pkg::COL_MAX : col_sum[14:0];
	assign row_upd = row_sat ? crp_pkg::ROW_MAX : row_sum[20:0];

	always_comb begin
		nxt = cur;
		do_row_start = 1'b0;
		unique case (cur.phase)
			crp_pkg::PH_START: begin
				priority if (char_byte == crp_pkg::CH_DOLLAR) begin
					nxt.phase = crp_pkg::PH_DOLLAR;
				end else if (is_letter) begin
					nxt.col_acc = col_upd;
					nxt.col_ovf = col_sat;
					nxt.phase   = crp_pkg::PH_LETTERS;
				end else begin
					nxt.phase = crp_pkg::PH_FAIL;
				end
			end
			crp_pkg::PH_DOLLAR: begin
				if (is_letter) begin
					nxt.col_acc = col_upd;
					nxt.col_ovf = col_sat;
					nxt.phase   = crp_pkg::PH_LETTERS;
				end else begin
					nxt.phase = crp_pkg::PH_FAIL;
				end
			end
			crp_pkg::PH_LETTERS: begin
				priority if (is_letter) begin
					nxt.col_acc = col_upd;
					nxt.col_ovf = col_sat;
				end else if (cur.col_ovf || (cur.col_acc == '0)) begin
					nxt.phase = crp_pkg::PH_FAIL;
				end else if (char_byte == crp_pkg::CH_DOLLAR) begin
					nxt.phase = crp_pkg::PH_ROWWS;
				end else begin
					do_row_start = 1'b1;
				end
			end
			crp_pkg::PH_ROWWS: begin
				do_row_start = 1'b1;
			end
			crp_pkg::PH_SIGN, crp_pkg::PH_DIGITS: begin
				if (is_digit) begin
					nxt.row_acc    = row_upd;
					nxt.row_ovf    = row_sat;
					nxt.digit_seen = 1'b1;
					nxt.phase      = crp_pkg::PH_DIGITS;
				end else begin
					nxt.phase = crp_pkg::PH_FAIL;
				end
			end
			default: begin
				nxt.phase = crp_pkg::PH_FAIL;
			end
		endcase

		// The row part opens with whitespace, a sign or its first digit.
		if (do_row_start) begin
			priority if (is_space) begin
				nxt.phase = crp_pkg::PH_ROWWS;
			end else if (char_byte == crp_pkg::CH_PLUS) begin
				nxt.phase = crp_pkg::PH_SIGN;
			end else if (char_byte == crp_pkg::CH_MINUS) begin
				nxt.row_neg = 1'b1;
				nxt.phase   = crp_pkg::PH_SIGN;
			end else if (is_digit) begin
				nxt.row_acc    = row_upd;
				nxt.row_ovf    = row_sat;
				nxt.digit_seen = 1'b1;
				nxt.phase      = crp_pkg::PH_DIGITS;
			end else begin
				nxt.phase = crp_pkg::PH_FAIL;
			end
		end
	end

	assign good = (nxt.phase == crp_pkg::PH_DIGITS) && nxt.digit_seen &&
		!nxt.col_ovf && (nxt.col_acc != '0) && (nxt.col_acc <= crp_pkg::COL_MAX) &&
		!nxt.row_ovf && !nxt.row_neg &&
		(nxt.row_acc != '0) && (nxt.row_acc <= crp_pkg::ROW_MAX);

	assign res.ok            = good;
	assign res.row_number    = good ? nxt.row_acc : '0;
	assign res.column_number = good ? nxt.col_acc : '0;

endmodule

>>> hdl/cell_reference_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_reference_parser_top: streaming A1 cell reference parser
// A reference such as $AB$12 enters one byte per word on the input channel
// (char_byte, last_char, in_valid, in_ready). On the word that carries
// last_char the block delivers one result word on the output channel
// (ok, row_number, column_number, out_valid, out_ready); other bytes give
// no result. A failed reference gives ok low with both numbers zero.
// The last byte is held in the input register, and the result register
// loads from the parse logic as that byte advances out of it.
// Throughput: one byte per cycle while no final byte waits on a stalled
// receiver, set by the single step of parse logic between the two registers.
// After each final byte the parse state returns to its start value, so the
// next reference may follow at once.
// When the receiver stalls, bytes that give no result keep flowing; a final
// byte waits in the input register until the result register frees, and
// in_ready drops only then.
// Reset (arst_n low) clears the parse state and empties both registers.
// ----------------------------------------------------------------------------
module cell_reference_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_byte,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [20:0] row_number,
	output logic [14:0] column_number
);

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             last_s1;
	logic             adv_s1;
	logic             out_valid_q;
	crp_pkg::state_t  state_q;
	crp_pkg::state_t  state_nxt;
	crp_pkg::result_t res_nxt;
	crp_pkg::result_t res_q;

	crp_step u_step (
		.cur       (state_q),
		.char_byte (char_s1),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	// A byte without a result never waits on the output side.
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= crp_pkg::STATE_RESET;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				state_q <= last_s1 ? crp_pkg::STATE_RESET : state_nxt;
			end
			if (adv_s1 && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_byte;
			last_s1 <= last_char;
		end
		if (adv_s1 && last_s1) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = res_q.ok;
	assign row_number    = res_q.row_number;
	assign column_number = res_q.column_number;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ok) |-> (row_number == '0) && (column_number == '0))
		else $error("failed reference carries nonzero numbers");

	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ok) |-> (row_number != '0) && (column_number != '0) &&
			(column_number <= crp_pkg::COL_MAX) && (row_number <= crp_pkg::ROW_MAX))
		else $error("valid reference outside its range");

	a_state_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (state_q == crp_pkg::STATE_RESET))
		else $error("parse state not restarted after final byte");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> valid_s1 && $stable(char_s1) && $stable(last_s1))
		else $error("stalled input register lost its byte");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q && $stable(res_q))
		else $error("stalled result changed");

endmodule
